// File: rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// shared constants, codes and types of the shortest path engine
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int WEIGHT_BITS  = 16;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = EIDX_W + 1;

  localparam int CMD_W      = 2;
  localparam int NODE_W     = 6;
  localparam int WEIGHT_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int DIST_W     = 24;
  localparam int PRED_W     = 7;
  localparam int VCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIST_W-1:0] UNREACHED = 24'd10000000;
  localparam logic [PRED_W-1:0] NO_PREV   = 7'h7F;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE       = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_VERTEX   = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [NODE_W-1:0]      from;
    logic [NODE_W-1:0]      to;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_len;
    logic [PRED_W-1:0] pred;
  } vert_t;

endpackage

// File: rtl/spd_in_if.sv
// ----------------------------------------------------------------------------
// spd_in_if
// command channel: add edge, run, clear
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::CMD_W-1:0]    cmd;
  logic [spd_pkg::NODE_W-1:0]   edge_from;
  logic [spd_pkg::NODE_W-1:0]   edge_to;
  logic [spd_pkg::WEIGHT_W-1:0] edge_weight;

  modport source (output valid, cmd, edge_from, edge_to, edge_weight, input ready);
  modport sink   (input valid, cmd, edge_from, edge_to, edge_weight, output ready);
endinterface

// File: rtl/spd_out_if.sv
// ----------------------------------------------------------------------------
// spd_out_if
// result channel: acknowledges and per-vertex results
// ----------------------------------------------------------------------------
interface spd_out_if;
  logic                                valid;
  logic                                ready;
  logic [spd_pkg::STATUS_W-1:0]        status;
  logic [spd_pkg::NODE_W-1:0]          vertex;
  logic [spd_pkg::DIST_W-1:0]          distance;
  logic signed [spd_pkg::PRED_W-1:0]   predecessor;
  logic                                last;

  modport source (output valid, status, vertex, distance, predecessor, last, input ready);
  modport sink   (input valid, status, vertex, distance, predecessor, last, output ready);
endinterface

// File: rtl/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/shortest_path_dijkstra.sv
// ----------------------------------------------------------------------------
// shortest_path_dijkstra
// single-source shortest paths over a stored directed graph
//
// in_if carries commands: add edge, run, clear. out_if carries results.
// an add edge or clear is answered by one acknowledge; edges stream in one
// per cycle while out_if keeps up.
// a run writes the distance ram, then per settled vertex scans the n
// distances and walks every stored edge (an edge address state and an edge
// data state per edge, plus a relax state when the edge leaves the settled
// vertex toward a vertex in use), then reads out n results, an address state
// and a data state each; the edge walk through the edge ram sets the run
// time. no command is taken during a run. result n-1 carries last.
// reset empties the edge store and sets vertex_count 64, source_vertex 0.
// results sit in one output register; while out_if stalls the block holds
// the result and takes no new command that would need the register.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
// ----------------------------------------------------------------------------
module shortest_path_dijkstra (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  spd_in_if.sink                          in_if,
  spd_out_if.source                       out_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_PICK, S_EADDR, S_EDATA, S_DDATA, S_OADDR, S_ODATA
  } state_e;

  state_e state_q;

  logic [spd_pkg::VCOUNT_W-1:0]    vcount_q;
  logic [spd_pkg::NODE_W-1:0]      src_q;
  logic [spd_pkg::ECNT_W-1:0]      total_q;
  logic [spd_pkg::MAX_VERTICES-1:0] settled_q;
  logic [spd_pkg::VCNT_W-1:0]      n_q;
  logic [spd_pkg::VCNT_W-1:0]      idx_q;
  logic                            rv_q;
  logic [spd_pkg::VIDX_W-1:0]      ridx_q;
  logic                            found_q;
  logic [spd_pkg::DIST_W-1:0]      best_q;
  logic [spd_pkg::VIDX_W-1:0]      u_q;
  logic [spd_pkg::DIST_W-1:0]      du_q;
  logic [spd_pkg::EIDX_W-1:0]      e_q;

  logic                            out_valid_q;
  spd_pkg::status_e                out_status_q;
  logic [spd_pkg::NODE_W-1:0]      out_vertex_q;
  logic [spd_pkg::DIST_W-1:0]      out_dist_q;
  logic [spd_pkg::PRED_W-1:0]      out_pred_q;
  logic                            out_last_q;

  logic                            in_fire;
  logic                            out_free;
  logic                            out_load;
  logic                            full;
  logic [spd_pkg::VCNT_W-1:0]      n_d;

  logic                            edge_we;
  logic                            edge_re;
  logic [$bits(spd_pkg::edge_t)-1:0] edge_rdata;
  spd_pkg::edge_t                  edge_wr;
  spd_pkg::edge_t                  ed;

  logic                            dist_we;
  logic [spd_pkg::VIDX_W-1:0]      dist_waddr;
  spd_pkg::vert_t                  dist_wr;
  logic                            dist_re;
  logic [spd_pkg::VIDX_W-1:0]      dist_raddr;
  logic [$bits(spd_pkg::vert_t)-1:0] dist_rdata;
  spd_pkg::vert_t                  drd;

  logic                            match;
  logic [spd_pkg::DIST_W-1:0]      cand;
  logic                            better;
  logic                            edge_done;
  logic                            src_ok;

  assign out_free = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && out_free;
  assign in_fire = in_if.valid && in_if.ready;
  assign full = (total_q == spd_pkg::ECNT_W'(spd_pkg::MAX_EDGES));
  assign out_load = (in_fire && ((in_if.cmd == spd_pkg::CMD_ADD) ||
                                 (in_if.cmd == spd_pkg::CMD_CLEAR))) ||
                    ((state_q == S_ODATA) && out_free);

  assign ed  = spd_pkg::edge_t'(edge_rdata);
  assign drd = spd_pkg::vert_t'(dist_rdata);

  // clamp of the vertex count in use
  always_comb begin
    if (vcount_q == '0) begin
      n_d = spd_pkg::VCNT_W'(1);
    end else if (vcount_q > spd_pkg::VCOUNT_W'(spd_pkg::MAX_VERTICES)) begin
      n_d = spd_pkg::VCNT_W'(spd_pkg::MAX_VERTICES);
    end else begin
      n_d = spd_pkg::VCNT_W'(vcount_q);
    end
  end

  assign match = (ed.from == spd_pkg::NODE_W'(u_q)) &&
                 ({1'b0, ed.to} < (spd_pkg::NODE_W + 1)'(n_q));
  assign cand = du_q + spd_pkg::DIST_W'(ed.weight);
  assign better = (drd.path_len > cand);
  assign edge_done = ((spd_pkg::ECNT_W'(e_q) + 1'b1) == total_q);
  assign src_ok = ({1'b0, src_q} < (spd_pkg::NODE_W + 1)'(n_q));

  // edge ram port control
  always_comb begin
    edge_we = in_fire && (in_if.cmd == spd_pkg::CMD_ADD) && !full;
    edge_wr = '{from: in_if.edge_from, to: in_if.edge_to,
                weight: in_if.edge_weight[spd_pkg::WEIGHT_BITS-1:0]};
    edge_re = (state_q == S_EADDR);
  end

  // distance ram port control
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = idx_q[spd_pkg::VIDX_W-1:0];
    dist_wr    = '{path_len: spd_pkg::UNREACHED, pred: spd_pkg::NO_PREV};
    dist_re    = 1'b0;
    dist_raddr = idx_q[spd_pkg::VIDX_W-1:0];
    case (state_q)
      S_INIT: begin
        dist_we = 1'b1;
        if (src_ok && ({1'b0, src_q} == (spd_pkg::NODE_W + 1)'(idx_q))) begin
          dist_wr.path_len = '0;
        end
      end
      S_SCAN: begin
        dist_re = (idx_q < n_q);
      end
      S_EDATA: begin
        dist_re    = match;
        dist_raddr = ed.to[spd_pkg::VIDX_W-1:0];
      end
      S_DDATA: begin
        dist_we    = better;
        dist_waddr = ed.to[spd_pkg::VIDX_W-1:0];
        dist_wr    = '{path_len: cand, pred: spd_pkg::PRED_W'(u_q)};
      end
      S_OADDR: begin
        dist_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  spd_ram #(
    .DEPTH (spd_pkg::MAX_EDGES),
    .WIDTH ($bits(spd_pkg::edge_t))
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (total_q[spd_pkg::EIDX_W-1:0]),
    .wdata_i (edge_wr),
    .re_i    (edge_re),
    .raddr_i (e_q),
    .rdata_o (edge_rdata)
  );

  spd_ram #(
    .DEPTH (spd_pkg::MAX_VERTICES),
    .WIDTH ($bits(spd_pkg::vert_t))
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wr),
    .re_i    (dist_re),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= spd_pkg::VCOUNT_W'(spd_pkg::MAX_VERTICES);
      src_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spd_pkg::CFG_VERTEX_COUNT: vcount_q <= cfg_data_i[spd_pkg::VCOUNT_W-1:0];
        spd_pkg::CFG_SOURCE:       src_q    <= cfg_data_i[spd_pkg::NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= '0;
      settled_q    <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      rv_q         <= 1'b0;
      ridx_q       <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      u_q          <= '0;
      du_q         <= '0;
      e_q          <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= spd_pkg::ST_ACCEPTED;
      out_vertex_q <= '0;
      out_dist_q   <= '0;
      out_pred_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            out_vertex_q <= '0;
            out_dist_q   <= '0;
            out_pred_q   <= spd_pkg::NO_PREV;
            out_last_q   <= 1'b1;
            case (in_if.cmd)
              spd_pkg::CMD_ADD: begin
                out_status_q <= full ? spd_pkg::ST_DROPPED : spd_pkg::ST_ACCEPTED;
                if (!full) begin
                  total_q <= total_q + 1'b1;
                end
              end
              spd_pkg::CMD_CLEAR: begin
                out_status_q <= spd_pkg::ST_CLEARED;
                total_q      <= '0;
              end
              spd_pkg::CMD_RUN: begin
                n_q       <= n_d;
                idx_q     <= '0;
                settled_q <= '0;
                state_q   <= S_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          if (idx_q == n_q - 1'b1) begin
            idx_q   <= '0;
            rv_q    <= 1'b0;
            found_q <= 1'b0;
            state_q <= S_SCAN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (idx_q < n_q) begin
            rv_q   <= 1'b1;
            ridx_q <= idx_q[spd_pkg::VIDX_W-1:0];
            idx_q  <= idx_q + 1'b1;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              state_q <= S_PICK;
            end
          end
          // least unsettled distance, strict compare keeps the lowest index
          if (rv_q && !settled_q[ridx_q] && (!found_q || (drd.path_len < best_q))) begin
            found_q <= 1'b1;
            best_q  <= drd.path_len;
            u_q     <= ridx_q;
          end
        end
        S_PICK: begin
          if (!found_q) begin
            idx_q   <= '0;
            state_q <= S_OADDR;
          end else begin
            settled_q[u_q] <= 1'b1;
            du_q           <= best_q;
            e_q            <= '0;
            idx_q          <= '0;
            found_q        <= 1'b0;
            rv_q           <= 1'b0;
            state_q        <= (total_q == '0) ? S_SCAN : S_EADDR;
          end
        end
        S_EADDR: begin
          state_q <= S_EDATA;
        end
        S_EDATA: begin
          if (match) begin
            state_q <= S_DDATA;
          end else if (edge_done) begin
            state_q <= S_SCAN;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= S_EADDR;
          end
        end
        S_DDATA: begin
          if (edge_done) begin
            state_q <= S_SCAN;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= S_EADDR;
          end
        end
        S_OADDR: begin
          state_q <= S_ODATA;
        end
        S_ODATA: begin
          if (out_free) begin
            out_status_q <= spd_pkg::ST_VERTEX;
            out_vertex_q <= spd_pkg::NODE_W'(idx_q);
            out_dist_q   <= drd.path_len;
            out_pred_q   <= drd.pred;
            out_last_q   <= (idx_q == n_q - 1'b1);
            idx_q        <= idx_q + 1'b1;
            state_q      <= (idx_q == n_q - 1'b1) ? S_IDLE : S_OADDR;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = out_status_q;
  assign out_if.vertex      = out_vertex_q;
  assign out_if.distance    = out_dist_q;
  assign out_if.predecessor = out_pred_q;
  assign out_if.last        = out_last_q;

  // edge count never passes the store depth
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= spd_pkg::ECNT_W'(spd_pkg::MAX_EDGES))
    else $error("edge count beyond store depth");

  // relaxation only from a settled vertex
  a_relax_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DDATA) && dist_we |-> settled_q[u_q])
    else $error("relaxation from unsettled vertex");

  // last vertex result describes vertex n-1
  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == spd_pkg::ST_VERTEX) && out_last_q |->
      ((spd_pkg::NODE_W + 1)'(out_vertex_q) == (spd_pkg::NODE_W + 1)'(n_q - 1'b1)))
    else $error("last flag on wrong vertex");

  // a clear empties the store
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_if.cmd == spd_pkg::CMD_CLEAR) |=> (total_q == '0))
    else $error("clear did not empty the store");

endmodule
